// ----- design/dbwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwc_pkg
// Shared constants, register codes and helpers for the delay-based window
// control block.
// ----------------------------------------------------------------------------
package dbwc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int WIN_W         = 16;
    localparam int Q8_W          = 16;
    localparam int Q8_FRAC       = 8;
    localparam int STEP_W        = 8;
    localparam int CFG_AW        = 3;
    localparam int CFG_DW        = 16;
    localparam int MIN_RTT_W     = 32;
    localparam int OUT_DW        = 2 * WIN_W + MIN_RTT_W;

    localparam logic [WIN_W-1:0] MAX_WINDOW = 16'd65535;
    localparam logic [WIN_W-1:0] MIN_WINDOW = 16'd1;
    localparam logic [WIN_W-1:0] MIN_THRESH = 16'd2;

    // floor(x / 5) for x < 2^18 as (x * DIV5_RECIP) >> DIV5_SHIFT
    localparam int               X3_W        = WIN_W + 2;
    localparam int               DIV5_SHIFT  = 18;
    localparam logic [15:0]      DIV5_RECIP  = 16'd52429;

    localparam logic [CFG_AW-1:0] REG_ALPHA      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BETA       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_INIT_WIN   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_INIT_THR   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_START_STEP = 3'd4;
    localparam logic [CFG_AW-1:0] REG_AVOID_STEP = 3'd5;

    localparam logic [Q8_W-1:0]   ALPHA_RST      = 16'd102;
    localparam logic [Q8_W-1:0]   BETA_RST       = 16'd205;
    localparam logic [WIN_W-1:0]  INIT_WIN_RST   = 16'd1;
    localparam logic [WIN_W-1:0]  INIT_THR_RST   = 16'd10;
    localparam logic [STEP_W-1:0] START_STEP_RST = 8'd4;
    localparam logic [STEP_W-1:0] AVOID_STEP_RST = 8'd2;

    typedef struct packed {
        logic below;
        logic above;
    } t_cmp_res;

    function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] r;
        if (v < MIN_WINDOW) begin
            r = MIN_WINDOW;
        end else if (v > MAX_WINDOW) begin
            r = MAX_WINDOW;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [WIN_W-1:0] grow_win(input logic [WIN_W-1:0]  w,
                                                  input logic [STEP_W-1:0] step);
        logic [WIN_W:0] s;
        s = {1'b0, w} + {{(WIN_W - STEP_W + 1){1'b0}}, step};
        return (s > {1'b0, MAX_WINDOW}) ? MAX_WINDOW : s[WIN_W-1:0];
    endfunction

endpackage

// ----- design/delay_based_window_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_based_window_control
// Delay-based congestion window update, one result beat per ack beat.
// ----------------------------------------------------------------------------
// Sequence: a first ack goes straight to the update; otherwise the compare
//   runs, skipping the multiplies when rtt is not above base, else the
//   base*rtt multiply, then the alpha/beta scaling, plus control steps.
// Throughput: no new ack is taken until the previous one is through; a result
//   held in the output register by m_axis_tready delays the next ack.
// Reset: synchronous active low; registers to defaults, awaiting first ack.
// ----------------------------------------------------------------------------
module delay_based_window_control #(
    parameter int TIME_BITS = dbwc_pkg::TIME_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // send_time, ack_time
    input  logic [((2*TIME_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // window, threshold, min_rtt
    output logic [dbwc_pkg::OUT_DW-1:0]           m_axis_tdata,
    // in_slow_start
    output logic                                  m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic [dbwc_pkg::CFG_AW-1:0]           i_cfg_addr,
    input  logic [dbwc_pkg::CFG_DW-1:0]           i_cfg_data
);
    import dbwc_pkg::*;

    localparam int T = TIME_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [Q8_W-1:0]   r_alpha;
    logic [Q8_W-1:0]   r_beta;
    logic [WIN_W-1:0]  r_init_win;
    logic [WIN_W-1:0]  r_init_thr;
    logic [STEP_W-1:0] r_start_step;
    logic [STEP_W-1:0] r_avoid_step;

    logic [WIN_W-1:0]  r_win;
    logic [WIN_W-1:0]  r_thr;
    logic [T-1:0]      r_base;
    logic              r_first;
    logic [T-1:0]      r_rtt;
    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic              r_out_valid;
    logic [OUT_DW-1:0] r_out_data;
    logic              r_out_slow;

    logic [WIN_W-1:0]  n_win;
    logic [WIN_W-1:0]  n_thr;
    logic [T-1:0]      n_base;
    logic              n_slow;

    logic [T-1:0]      w_send;
    logic [T-1:0]      w_ack;
    logic [T-1:0]      w_diff;
    logic [T-1:0]      w_rtt;
    logic              w_in_fire;
    logic              w_cmp_start;
    logic              w_cmp_done;
    t_cmp_res          w_res;
    logic              w_upd_fire;

    logic [X3_W-1:0]        w_x3;
    logic [X3_W+15:0]       w_q_prod;
    logic [WIN_W-1:0]       w_q;
    logic [WIN_W-1:0]       w_t;
    logic [WIN_W-1:0]       w_dec;
    logic [T+MIN_RTT_W-1:0] w_base_ext;

    assign w_send = s_axis_tdata[T-1:0];
    assign w_ack  = s_axis_tdata[2*T-1:T];
    assign w_diff = w_ack - w_send;
    assign w_rtt  = (w_diff == '0) ? T'(1) : w_diff;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_cmp_start   = w_in_fire && !r_first;
    assign w_upd_fire    = (r_state == S_UPD) && (!r_out_valid || m_axis_tready);

    dbwc_delay_cmp #(.TIME_BITS(T)) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cmp_start),
        .i_rtt   (w_rtt),
        .i_base  (r_base),
        .i_win   (r_win),
        .i_alpha (r_alpha),
        .i_beta  (r_beta),
        .o_done  (w_cmp_done),
        .o_res   (w_res)
    );

    // threshold on congestion: max(2, floor(window*3/5))
    assign w_x3     = {2'b00, r_win} + {1'b0, r_win, 1'b0};
    assign w_q_prod = w_x3 * DIV5_RECIP;
    assign w_q      = w_q_prod[DIV5_SHIFT+WIN_W-1:DIV5_SHIFT];
    assign w_t      = (w_q < MIN_THRESH) ? MIN_THRESH : w_q;
    assign w_dec    = (r_win > ({{(WIN_W-STEP_W){1'b0}}, r_avoid_step} + MIN_WINDOW))
                    ? (r_win - {{(WIN_W-STEP_W){1'b0}}, r_avoid_step}) : MIN_WINDOW;

    always_comb begin
        n_win  = r_win;
        n_thr  = r_thr;
        n_base = r_base;
        n_slow = 1'b1;
        if (r_first) begin
            n_win  = grow_win(r_win, r_start_step);
            n_base = r_rtt;
        end else begin
            n_slow = (r_win < r_thr);
            if (n_slow) begin
                priority if (w_res.below) begin
                    n_win = grow_win(r_win, r_start_step);
                end else if (w_res.above) begin
                    n_thr = w_t;
                    n_win = clamp_win(w_t);
                end else begin
                    n_win = r_win;
                end
            end else begin
                priority if (w_res.below) begin
                    n_win = grow_win(r_win, r_avoid_step);
                end else if (w_res.above) begin
                    n_win = w_dec;
                end else begin
                    n_win = r_win;
                end
            end
            if (r_base > r_rtt) begin
                n_base = r_rtt;
            end
        end
    end

    assign w_base_ext = {{MIN_RTT_W{1'b0}}, n_base};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_fire) n_state = r_first ? S_UPD : S_RUN;
            S_RUN:   if (w_cmp_done) n_state = S_UPD;
            S_UPD:   if (w_upd_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha      <= ALPHA_RST;
            r_beta       <= BETA_RST;
            r_init_win   <= INIT_WIN_RST;
            r_init_thr   <= INIT_THR_RST;
            r_start_step <= START_STEP_RST;
            r_avoid_step <= AVOID_STEP_RST;
            r_win        <= clamp_win(INIT_WIN_RST);
            r_thr        <= INIT_THR_RST;
            r_base       <= '0;
            r_first      <= 1'b1;
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_ALPHA:      r_alpha <= i_cfg_data;
                    REG_BETA:       r_beta  <= i_cfg_data;
                    REG_INIT_WIN: begin
                        r_init_win <= i_cfg_data;
                        if (r_first) r_win <= clamp_win(i_cfg_data);
                    end
                    REG_INIT_THR: begin
                        r_init_thr <= i_cfg_data;
                        if (r_first) r_thr <= i_cfg_data;
                    end
                    REG_START_STEP: r_start_step <= i_cfg_data[STEP_W-1:0];
                    REG_AVOID_STEP: r_avoid_step <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (w_upd_fire) begin
                r_win       <= n_win;
                r_thr       <= n_thr;
                r_base      <= n_base;
                r_first     <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_rtt <= w_rtt;
        end
        if (w_upd_fire) begin
            r_out_data <= {w_base_ext[MIN_RTT_W-1:0], n_thr, n_win};
            r_out_slow <= n_slow;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_slow;

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmp_done |-> (r_state == S_RUN))
        else $error("compare result outside run phase");

    a_upd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_fire |=> (m_axis_tvalid && !r_first))
        else $error("update did not load result or clear first-ack flag");

    a_win_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win != '0)
        else $error("window dropped to zero");

endmodule

// ----- design/dbwc_ser_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwc_ser_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dbwc_ser_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic             o_done,
    output logic [WA+WB-1:0] o_prod
);
    localparam int PW = WA + WB;
    localparam int CW = $clog2(WB + 1);

    logic [WA-1:0] r_a;
    logic [PW-1:0] r_p;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [WA:0]   w_addend;
    logic [WA:0]   w_sum;

    assign w_addend = r_p[0] ? {1'b0, r_a} : '0;
    assign w_sum    = {1'b0, r_p[PW-1:WB]} + w_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(WB);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{WA{1'b0}}, i_b};
        end else if (r_cnt != '0) begin
            r_p <= {w_sum, r_p[WB-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

// ----- design/dbwc_delay_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwc_delay_cmp
// Exact test of window*(1/base - 1/rtt) against alpha and beta (Q8.8),
// cross-multiplied and evaluated with bit-serial multipliers.
// ----------------------------------------------------------------------------
module dbwc_delay_cmp #(
    parameter int TIME_BITS = dbwc_pkg::TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [TIME_BITS-1:0]        i_rtt,
    input  logic [TIME_BITS-1:0]        i_base,
    input  logic [dbwc_pkg::WIN_W-1:0]  i_win,
    input  logic [dbwc_pkg::Q8_W-1:0]   i_alpha,
    input  logic [dbwc_pkg::Q8_W-1:0]   i_beta,
    output logic                        o_done,
    output dbwc_pkg::t_cmp_res          o_res
);
    import dbwc_pkg::*;

    localparam int T  = TIME_BITS;
    localparam int PW = 2 * T;
    localparam int AW = PW + Q8_W;
    localparam int NW = T + WIN_W;

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_BASE  = 2'd1;
    localparam logic [1:0] C_SCALE = 2'd2;
    localparam logic [1:0] C_CMP   = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic          r_done;
    t_cmp_res      r_res;

    logic          w_le;
    logic          w_mul_go;
    logic          w_p_done;
    logic          w_n_done;
    logic          w_a_done;
    logic          w_b_done;
    logic [PW-1:0] w_p;
    logic [NW-1:0] w_n;
    logic [AW-1:0] w_la;
    logic [AW-1:0] w_lb;
    logic [AW-1:0] w_n_ext;
    logic [T-1:0]  w_excess;

    assign w_le     = (i_rtt <= i_base);
    assign w_mul_go = i_start && !w_le;
    assign w_excess = i_rtt - i_base;

    // base * rtt
    dbwc_ser_mul #(.WA(T), .WB(T)) u_mul_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_go),
        .i_a     (i_base),
        .i_b     (i_rtt),
        .o_done  (w_p_done),
        .o_prod  (w_p)
    );

    // (rtt - base) * window, runs alongside base * rtt
    dbwc_ser_mul #(.WA(T), .WB(WIN_W)) u_mul_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_go),
        .i_a     (w_excess),
        .i_b     (i_win),
        .o_done  (w_n_done),
        .o_prod  (w_n)
    );

    dbwc_ser_mul #(.WA(PW), .WB(Q8_W)) u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_p_done),
        .i_a     (w_p),
        .i_b     (i_alpha),
        .o_done  (w_a_done),
        .o_prod  (w_la)
    );

    dbwc_ser_mul #(.WA(PW), .WB(Q8_W)) u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_p_done),
        .i_a     (w_p),
        .i_b     (i_beta),
        .o_done  (w_b_done),
        .o_prod  (w_lb)
    );

    assign w_n_ext = AW'({w_n, {Q8_FRAC{1'b0}}});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (w_mul_go) n_state = C_BASE;
            C_BASE:  if (w_p_done) n_state = C_SCALE;
            C_SCALE: if (w_a_done) n_state = C_CMP;
            C_CMP:   n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (i_start && w_le) || (r_state == C_CMP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && w_le) begin
            r_res.below <= !((i_rtt == i_base) && (i_alpha == '0));
            r_res.above <= 1'b0;
        end else if (r_state == C_CMP) begin
            r_res.below <= (w_n_ext < w_la);
            r_res.above <= (w_n_ext > w_lb);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_n_before_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_n_done |-> (r_state == C_BASE))
        else $error("window product finished outside base phase");

    a_ab_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_a_done == w_b_done)
        else $error("alpha and beta products out of step");

endmodule
